// ===== hdl/tnrx_pkg.sv =====
// Package for the telnet receive option negotiator.
// Telnet codes, register indexes, the job record passed from parser to reply generator, helpers.
// No dependencies.
package tnrx_pkg;

   localparam int NAME_CHARS_DEFAULT  = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] T_IAC  = 8'd255;
   localparam logic [7:0] T_DONT = 8'd254;
   localparam logic [7:0] T_DO   = 8'd253;
   localparam logic [7:0] T_WONT = 8'd252;
   localparam logic [7:0] T_WILL = 8'd251;
   localparam logic [7:0] T_SB   = 8'd250;
   localparam logic [7:0] T_SE   = 8'd240;
   localparam logic [7:0] T_SEND = 8'd1;
   localparam logic [7:0] T_IS   = 8'd0;

   localparam logic [7:0] OPT_ECHO   = 8'd1;
   localparam logic [7:0] OPT_SGA    = 8'd3;
   localparam logic [7:0] OPT_STATUS = 8'd5;
   localparam logic [7:0] OPT_TTYPE  = 8'd24;
   localparam logic [7:0] OPT_NAWS   = 8'd31;
   localparam logic [7:0] OPT_TSPEED = 8'd32;

   localparam int NOPTS = 6;
   // per option: bit 0 DO, bit 1 WILL
   localparam int FLAG_DO   = 0;
   localparam int FLAG_WILL = 1;
   localparam logic [2*NOPTS-1:0] FLAGS_RESET = 12'b10_00_10_10_10_11;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_COMMA = 8'h2c;

   typedef enum logic [2:0] {
      REG_COLUMNS, REG_ROWS, REG_RX_BAUD, REG_TX_BAUD, REG_NAME, REG_NAME_LEN
   } reg_index_type;

   typedef enum logic [2:0] {
      JOB_DATA,
      JOB_ERR,
      JOB_NEG3,
      JOB_NEG6,
      JOB_NAWS,
      JOB_STATUS,
      JOB_TTYPE,
      JOB_TSPEED
   } job_kind_type;

   typedef struct packed {
      job_kind_type         kind;
      logic [7:0]           cmd;    // reply command for JOB_NEG3
      logic [7:0]           opt;    // option, or the data byte for JOB_DATA
      logic                 echo;
      logic [2*NOPTS-1:0]   flags;
   } job_type;

   typedef struct packed {
      logic       found;
      logic [2:0] idx;
   } opt_hit_type;

   function automatic opt_hit_type opt_lookup(input logic [7:0] code);
      opt_hit_type h;
      h.found = 1'b1;
      h.idx   = 3'd0;
      unique case (code)
         OPT_ECHO:   h.idx = 3'd0;
         OPT_SGA:    h.idx = 3'd1;
         OPT_STATUS: h.idx = 3'd2;
         OPT_TTYPE:  h.idx = 3'd3;
         OPT_NAWS:   h.idx = 3'd4;
         OPT_TSPEED: h.idx = 3'd5;
         default:    h.found = 1'b0;
      endcase
      return h;
   endfunction

   function automatic logic [7:0] opt_code(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = OPT_ECHO;
         3'd1:    c = OPT_SGA;
         3'd2:    c = OPT_STATUS;
         3'd3:    c = OPT_TTYPE;
         3'd4:    c = OPT_NAWS;
         default: c = OPT_TSPEED;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/tnrx_front.sv =====
// Parser for the received byte stream: holds the telnet phase and option state.
// Emits one job record per byte that needs a result. Uses tnrx_pkg.
module tnrx_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       rx_byte,
   output logic             push_valid,
   output tnrx_pkg::job_type push_job,
   input  logic             push_ready
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_IAC, PH_OPT, PH_SBOPT, PH_SBSEND, PH_SBIAC, PH_SBSE,
      PH_SKIP, PH_SKIPIAC
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  opt_ff, opt_in;
   logic [2*tnrx_pkg::NOPTS-1:0] flags_ff, flags_in;
   logic        echo_ff, echo_in;
   logic        accept;
   tnrx_pkg::opt_hit_type hit;
   tnrx_pkg::job_type     job;
   logic        push;

   assign req_ready = push_ready;
   assign accept    = req_valid & push_ready;
   assign hit       = tnrx_pkg::opt_lookup(rx_byte);

   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      opt_in   = opt_ff;
      flags_in = flags_ff;
      echo_in  = echo_ff;
      push     = 1'b0;
      job.kind = tnrx_pkg::JOB_DATA;
      job.cmd  = 8'd0;
      job.opt  = rx_byte;
      unique case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == tnrx_pkg::T_IAC) phase_in = PH_IAC;
            else push = 1'b1;
         end
         PH_IAC: begin
            phase_in = PH_IDLE;
            if (rx_byte == tnrx_pkg::T_IAC) begin
               push = 1'b1;
            end else if (rx_byte == tnrx_pkg::T_WILL || rx_byte == tnrx_pkg::T_WONT ||
                         rx_byte == tnrx_pkg::T_DO || rx_byte == tnrx_pkg::T_DONT) begin
               cmd_in   = rx_byte;
               phase_in = PH_OPT;
            end else if (rx_byte == tnrx_pkg::T_SB) begin
               phase_in = PH_SBOPT;
            end
         end
         PH_OPT: begin
            phase_in = PH_IDLE;
            push     = 1'b1;
            job.kind = tnrx_pkg::JOB_NEG3;
            if (!hit.found) begin
               job.cmd = (cmd_ff == tnrx_pkg::T_DO) ? tnrx_pkg::T_WONT : tnrx_pkg::T_DONT;
            end else if (rx_byte == tnrx_pkg::OPT_ECHO) begin
               if (cmd_ff == tnrx_pkg::T_DO) begin
                  echo_in = 1'b1;
                  flags_in[tnrx_pkg::FLAG_DO] = 1'b1;
               end else if (cmd_ff == tnrx_pkg::T_DONT) begin
                  echo_in = 1'b0;
                  flags_in[tnrx_pkg::FLAG_DO] = 1'b0;
               end
               job.cmd = (cmd_ff == tnrx_pkg::T_DO) ? tnrx_pkg::T_WILL : tnrx_pkg::T_WONT;
            end else begin
               case (cmd_ff)
                  tnrx_pkg::T_DO: begin
                     flags_in[{hit.idx, 1'b0}] = 1'b1;
                     job.cmd = tnrx_pkg::T_WILL;
                     if (rx_byte == tnrx_pkg::OPT_NAWS) job.kind = tnrx_pkg::JOB_NAWS;
                  end
                  tnrx_pkg::T_WILL: job.kind = tnrx_pkg::JOB_NEG6;
                  tnrx_pkg::T_DONT: begin
                     flags_in[{hit.idx, 1'b0}] = 1'b0;
                     job.cmd = tnrx_pkg::T_WONT;
                  end
                  default: job.cmd = tnrx_pkg::T_DONT;
               endcase
            end
         end
         PH_SBOPT: begin
            opt_in = rx_byte;
            if (rx_byte == tnrx_pkg::OPT_STATUS || rx_byte == tnrx_pkg::OPT_TTYPE ||
                rx_byte == tnrx_pkg::OPT_TSPEED)
               phase_in = PH_SBSEND;
            else
               phase_in = (rx_byte == tnrx_pkg::T_IAC) ? PH_SKIPIAC : PH_SKIP;
         end
         PH_SBSEND, PH_SBIAC, PH_SBSE: begin
            if (phase_ff == PH_SBSEND && rx_byte == tnrx_pkg::T_SEND) begin
               phase_in = PH_SBIAC;
            end else if (phase_ff == PH_SBIAC && rx_byte == tnrx_pkg::T_IAC) begin
               phase_in = PH_SBSE;
            end else if (phase_ff == PH_SBSE && rx_byte == tnrx_pkg::T_SE) begin
               phase_in = PH_IDLE;
               push     = 1'b1;
               job.opt  = opt_ff;
               if (opt_ff == tnrx_pkg::OPT_STATUS)     job.kind = tnrx_pkg::JOB_STATUS;
               else if (opt_ff == tnrx_pkg::OPT_TTYPE) job.kind = tnrx_pkg::JOB_TTYPE;
               else                                    job.kind = tnrx_pkg::JOB_TSPEED;
            end else begin
               // malformed send request
               phase_in = PH_IDLE;
               push     = 1'b1;
               job.kind = tnrx_pkg::JOB_ERR;
               job.opt  = 8'd0;
            end
         end
         PH_SKIP: if (rx_byte == tnrx_pkg::T_IAC) phase_in = PH_SKIPIAC;
         PH_SKIPIAC: phase_in = (rx_byte == tnrx_pkg::T_SE) ? PH_IDLE : PH_SKIP;
         default: phase_in = PH_IDLE;
      endcase
      job.echo  = echo_in;
      job.flags = flags_in;
   end

   assign push_valid = accept & push;
   assign push_job   = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cmd_ff   <= 8'd0;
         opt_ff   <= 8'd0;
         flags_ff <= tnrx_pkg::FLAGS_RESET;
         echo_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         opt_ff   <= opt_in;
         flags_ff <= flags_in;
         echo_ff  <= echo_in;
      end
   end

endmodule

// ===== hdl/tnrx_queue.sv =====
// Short job queue between parser and reply generator.
// Circular buffer of job records. Uses tnrx_pkg.
module tnrx_queue #(
   parameter int DEPTH = tnrx_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tnrx_pkg::job_type in_job,
   output logic              out_valid,
   input  logic              out_ready,
   output tnrx_pkg::job_type out_job
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   tnrx_pkg::job_type mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;

   assign in_ready  = (count_ff != CW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_job   = mem[rd_ptr_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= in_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("queue count over depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

endmodule

// ===== hdl/tnrx_back.sv =====
// Reply generator: turns job records into result bytes, one per cycle while rsp_ready allows.
// Holds the binary to decimal converter and the output register. Uses tnrx_pkg.
module tnrx_back #(
   parameter int NAME_CHARS = tnrx_pkg::NAME_CHARS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  tnrx_pkg::job_type job,
   input  logic [15:0]       window_columns,
   input  logic [15:0]       window_rows,
   input  logic [21:0]       receive_baud,
   input  logic [21:0]       transmit_baud,
   input  logic [63:0]       terminal_name,
   input  logic [3:0]        terminal_name_length,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_to_remote,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last_of_run,
   output logic              rsp_protocol_error,
   output logic              rsp_local_echo
);

   typedef enum logic [3:0] {
      S_IDLE, S_CONV, S_HEAD, S_WIN, S_NAME, S_STAT, S_RXD, S_COMMA, S_TXD, S_TAIL
   } state_type;

   localparam int BIN_W = 22;
   localparam int BCD_W = 28;

   state_type         state_ff, state_in;
   tnrx_pkg::job_type job_ff, job_in;
   logic [4:0]        idx_ff, idx_in;
   logic              dup_ff, dup_in;
   logic              started_ff, started_in;
   logic [BIN_W-1:0]  bin_rx_ff, bin_rx_in, bin_tx_ff, bin_tx_in;
   logic [BCD_W-1:0]  bcd_rx_ff, bcd_rx_in, bcd_tx_ff, bcd_tx_in;
   logic [BCD_W-1:0]  dab_rx, dab_tx;
   logic              valid_ff, valid_in, remote_ff, remote_in, last_ff, last_in;
   logic              err_ff, err_in, echo_ff, echo_in;
   logic [7:0]        byte_ff, byte_in;

   logic              out_free, emit, e_remote, e_last, e_err;
   logic [7:0]        e_byte, hdr_b, win_b, name_b, cur_b;
   logic [2:0]        hdr_last;
   logic [3:0]        name_n, digit;
   logic [31:0]       win_word;
   logic [1:0]        win_sel;
   logic              slot_bit;

   function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] v);
      logic [BCD_W-1:0] r;
      r = v;
      for (int d = 0; d < BCD_W / 4; d++)
         if (r[4*d +: 4] >= 4'd5) r[4*d +: 4] = r[4*d +: 4] + 4'd3;
      return r;
   endfunction

   assign dab_rx    = dabble(bcd_rx_ff);
   assign dab_tx    = dabble(bcd_tx_ff);
   assign out_free  = !valid_ff || rsp_ready;
   assign job_ready = (state_ff == S_IDLE);
   assign name_n    = (terminal_name_length > 4'(NAME_CHARS)) ? 4'(NAME_CHARS)
                                                                : terminal_name_length;
   assign win_word  = {window_columns, window_rows};
   assign win_sel   = 2'd3 - idx_ff[1:0];
   assign win_b     = win_word[{win_sel, 3'b000} +: 8];
   assign name_b    = terminal_name[{idx_ff[2:0], 3'b000} +: 8];
   assign slot_bit  = idx_ff[0] ? job_ff.flags[{idx_ff[3:1], 1'b0}]
                                : job_ff.flags[{idx_ff[3:1], 1'b1}];
   assign digit     = (state_ff == S_RXD) ? bcd_rx_ff[{idx_ff[2:0], 2'b00} +: 4]
                                          : bcd_tx_ff[{idx_ff[2:0], 2'b00} +: 4];
   assign cur_b     = (state_ff == S_WIN) ? win_b : name_b;

   always_comb begin
      hdr_b    = tnrx_pkg::T_IAC;
      hdr_last = 3'd3;
      unique case (job_ff.kind)
         tnrx_pkg::JOB_DATA, tnrx_pkg::JOB_ERR: begin
            hdr_b    = job_ff.opt;
            hdr_last = 3'd0;
         end
         tnrx_pkg::JOB_NEG3: begin
            hdr_last = 3'd2;
            if (idx_ff[2:0] == 3'd1)      hdr_b = job_ff.cmd;
            else if (idx_ff[2:0] == 3'd2) hdr_b = job_ff.opt;
         end
         tnrx_pkg::JOB_NEG6, tnrx_pkg::JOB_NAWS: begin
            hdr_last = 3'd5;
            case (idx_ff[2:0])
               3'd1: hdr_b = tnrx_pkg::T_WILL;
               3'd2, 3'd5: hdr_b = job_ff.opt;
               3'd4: hdr_b = (job_ff.kind == tnrx_pkg::JOB_NAWS) ? tnrx_pkg::T_SB
                                                                 : tnrx_pkg::T_WILL;
               default: hdr_b = tnrx_pkg::T_IAC;
            endcase
            // WILL after DO reply for the plain WILL case
            if (job_ff.kind == tnrx_pkg::JOB_NEG6 && idx_ff[2:0] == 3'd1)
               hdr_b = tnrx_pkg::T_DO;
         end
         default: begin
            case (idx_ff[2:0])
               3'd1: hdr_b = tnrx_pkg::T_SB;
               3'd2: hdr_b = job_ff.opt;
               3'd3: hdr_b = tnrx_pkg::T_IS;
               default: hdr_b = tnrx_pkg::T_IAC;
            endcase
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      idx_in     = idx_ff;
      dup_in     = dup_ff;
      started_in = started_ff;
      bin_rx_in  = bin_rx_ff;
      bin_tx_in  = bin_tx_ff;
      bcd_rx_in  = bcd_rx_ff;
      bcd_tx_in  = bcd_tx_ff;
      emit       = 1'b0;
      e_remote   = 1'b1;
      e_byte     = tnrx_pkg::T_IAC;
      e_last     = 1'b0;
      e_err      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_in     = job;
               idx_in     = '0;
               dup_in     = 1'b0;
               started_in = 1'b0;
               if (job.kind == tnrx_pkg::JOB_TSPEED) begin
                  bin_rx_in = receive_baud;
                  bin_tx_in = transmit_baud;
                  bcd_rx_in = '0;
                  bcd_tx_in = '0;
                  state_in  = S_CONV;
               end else begin
                  state_in = S_HEAD;
               end
            end
         end
         S_CONV: begin
            bcd_rx_in = {dab_rx[BCD_W-2:0], bin_rx_ff[BIN_W-1]};
            bcd_tx_in = {dab_tx[BCD_W-2:0], bin_tx_ff[BIN_W-1]};
            bin_rx_in = {bin_rx_ff[BIN_W-2:0], 1'b0};
            bin_tx_in = {bin_tx_ff[BIN_W-2:0], 1'b0};
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == 5'(BIN_W - 1)) begin
               idx_in   = '0;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            if (out_free) begin
               emit     = 1'b1;
               e_byte   = hdr_b;
               e_remote = !(job_ff.kind == tnrx_pkg::JOB_DATA ||
                            job_ff.kind == tnrx_pkg::JOB_ERR);
               e_err    = (job_ff.kind == tnrx_pkg::JOB_ERR);
               idx_in   = idx_ff + 1'b1;
               if (idx_ff[2:0] == hdr_last) begin
                  idx_in = '0;
                  case (job_ff.kind)
                     tnrx_pkg::JOB_NAWS:   state_in = S_WIN;
                     tnrx_pkg::JOB_STATUS: state_in = S_STAT;
                     tnrx_pkg::JOB_TTYPE:  state_in = (name_n == 4'd0) ? S_TAIL : S_NAME;
                     tnrx_pkg::JOB_TSPEED: begin
                        state_in = S_RXD;
                        idx_in   = 5'd6;
                     end
                     default: begin
                        e_last   = 1'b1;
                        state_in = S_IDLE;
                     end
                  endcase
               end
            end
         end
         S_WIN, S_NAME: begin
            if (out_free) begin
               emit   = 1'b1;
               e_byte = cur_b;
               // 255 goes out twice
               if (cur_b == tnrx_pkg::T_IAC && !dup_ff) begin
                  dup_in = 1'b1;
               end else begin
                  dup_in = 1'b0;
                  idx_in = idx_ff + 1'b1;
                  if ((state_ff == S_WIN && idx_ff[1:0] == 2'd3) ||
                      (state_ff == S_NAME && idx_ff == {1'b0, name_n - 4'd1})) begin
                     idx_in   = '0;
                     state_in = S_TAIL;
                  end
               end
            end
         end
         S_STAT: begin
            // twelve slots: WILL then DO for each option, ascending code
            if (!slot_bit || out_free) begin
               if (slot_bit) begin
                  emit   = 1'b1;
                  e_byte = !dup_ff ? (idx_ff[0] ? tnrx_pkg::T_DO : tnrx_pkg::T_WILL)
                                   : tnrx_pkg::opt_code(idx_ff[3:1]);
                  dup_in = !dup_ff;
               end
               if (!slot_bit || dup_ff) begin
                  idx_in = idx_ff + 1'b1;
                  if (idx_ff == 5'(2 * tnrx_pkg::NOPTS - 1)) begin
                     idx_in   = '0;
                     state_in = S_TAIL;
                  end
               end
            end
         end
         S_RXD, S_TXD: begin
            if (!started_ff && digit == 4'd0 && idx_ff != '0) begin
               idx_in = idx_ff - 1'b1;
            end else if (out_free) begin
               emit       = 1'b1;
               e_byte     = tnrx_pkg::CH_ZERO + {4'd0, digit};
               started_in = 1'b1;
               idx_in     = idx_ff - 1'b1;
               if (idx_ff == '0) begin
                  started_in = 1'b0;
                  idx_in     = '0;
                  state_in   = (state_ff == S_RXD) ? S_COMMA : S_TAIL;
               end
            end
         end
         S_COMMA: begin
            if (out_free) begin
               emit     = 1'b1;
               e_byte   = tnrx_pkg::CH_COMMA;
               idx_in   = 5'd6;
               state_in = S_TXD;
            end
         end
         S_TAIL: begin
            if (out_free) begin
               emit   = 1'b1;
               idx_in = idx_ff + 1'b1;
               if (idx_ff[0]) begin
                  e_byte   = tnrx_pkg::T_SE;
                  e_last   = 1'b1;
                  idx_in   = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      valid_in  = valid_ff && !rsp_ready;
      remote_in = remote_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      err_in    = err_ff;
      echo_in   = echo_ff;
      if (emit) begin
         valid_in  = 1'b1;
         remote_in = e_remote;
         byte_in   = e_byte;
         last_in   = e_last;
         err_in    = e_err;
         echo_in   = job_ff.echo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         idx_ff   <= '0;
         dup_ff   <= 1'b0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         idx_ff     <= idx_in;
         dup_ff     <= dup_in;
         started_ff <= started_in;
      end
      job_ff    <= job_in;
      bin_rx_ff <= bin_rx_in;
      bin_tx_ff <= bin_tx_in;
      bcd_rx_ff <= bcd_rx_in;
      bcd_tx_ff <= bcd_tx_in;
      remote_ff <= remote_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      err_ff    <= err_in;
      echo_ff   <= echo_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_to_remote      = remote_ff;
   assign rsp_out_byte       = byte_ff;
   assign rsp_last_of_run    = last_ff;
   assign rsp_protocol_error = err_ff;
   assign rsp_local_echo     = echo_ff;

   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_protocol_error |-> rsp_last_of_run && !rsp_to_remote &&
                                          rsp_out_byte == 8'd0)
      else $error("error result malformed");
   a_term_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_to_remote |-> rsp_last_of_run)
      else $error("terminal byte not last of run");
   a_conv_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CONV |=> state_ff == S_CONV || state_ff == S_HEAD)
      else $error("converter left early");

endmodule

// ===== hdl/telnet_rx_option_negotiator.sv =====
// Top level of the telnet receive option negotiator.
// Holds the configuration registers; joins tnrx_front, tnrx_queue, tnrx_back.
//
// Received bytes enter one per cycle on req_ while the queue has room; each
// byte that causes results becomes a job in a QUEUE_DEPTH deep queue, and the
// reply generator drains a job at up to one result byte per cycle on rsp_
// while rsp_ready allows. A data byte or an error gives one result byte, a
// negotiation reply three or six, the window size reply twelve plus one for
// each doubled 255. A STATUS reply sends two bytes for each set flag slot and
// none for a clear one. A terminal speed reply first runs the binary to
// decimal conversion of both speeds, then skips the leading zeros of each
// speed. Input stalls only while the queue is full.
// Configuration writes on csr_ are taken every cycle; csr_index values six and
// seven are ignored.
module telnet_rx_option_negotiator #(
   parameter int NAME_CHARS  = tnrx_pkg::NAME_CHARS_DEFAULT,
   parameter int QUEUE_DEPTH = tnrx_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_to_remote,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_protocol_error,
   output logic        rsp_local_echo,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [15:0] columns_ff, rows_ff;
   logic [21:0] rx_baud_ff, tx_baud_ff;
   logic [63:0] name_ff;
   logic [3:0]  name_len_ff;

   logic              f_valid, f_ready, b_valid, b_ready;
   tnrx_pkg::job_type f_job, b_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff  <= 16'd80;
         rows_ff     <= 16'd24;
         rx_baud_ff  <= 22'd9600;
         tx_baud_ff  <= 22'd9600;
         name_ff     <= '0;
         name_len_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            tnrx_pkg::REG_COLUMNS:  columns_ff  <= csr_data[15:0];
            tnrx_pkg::REG_ROWS:     rows_ff     <= csr_data[15:0];
            tnrx_pkg::REG_RX_BAUD:  rx_baud_ff  <= csr_data[21:0];
            tnrx_pkg::REG_TX_BAUD:  tx_baud_ff  <= csr_data[21:0];
            tnrx_pkg::REG_NAME:     name_ff     <= csr_data;
            tnrx_pkg::REG_NAME_LEN: name_len_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   tnrx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .rx_byte    (req_rx_byte),
      .push_valid (f_valid),
      .push_job   (f_job),
      .push_ready (f_ready)
   );

   tnrx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_job    (f_job),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_job   (b_job)
   );

   tnrx_back #(.NAME_CHARS(NAME_CHARS)) u_back (
      .clock                (clock),
      .reset                (reset),
      .job_valid            (b_valid),
      .job_ready            (b_ready),
      .job                  (b_job),
      .window_columns       (columns_ff),
      .window_rows          (rows_ff),
      .receive_baud         (rx_baud_ff),
      .transmit_baud        (tx_baud_ff),
      .terminal_name        (name_ff),
      .terminal_name_length (name_len_ff),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_to_remote        (rsp_to_remote),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_last_of_run      (rsp_last_of_run),
      .rsp_protocol_error   (rsp_protocol_error),
      .rsp_local_echo       (rsp_local_echo)
   );

endmodule
